FILE: src/kpsd_pkg.sv
`timescale 1ns / 1ps

package kpsd_pkg;

  localparam int COL_W   = 3;
  localparam int ROW_W   = 4;
  localparam int KEY_W   = 4;
  localparam int CLASS_W = 2;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 16;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_SHORT_LIMIT  = 2'd0;
  localparam reg_idx_t REG_MEDIUM_LIMIT = 2'd1;
  localparam reg_idx_t REG_LONG_LIMIT   = 2'd2;

  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET  = 16'd10000;
  localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RESET = 16'd25000;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RESET   = 16'd40000;

  localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  localparam logic [CLASS_W-1:0] CLASS_SHORT  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_LONG   = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_HELD   = 2'd3;

  // Indexed by column, then row, both counted from zero.
  localparam logic [KEY_W-1:0] KEY_MAP [0:2][0:3] = '{
    '{4'd1, 4'd4, 4'd7, KEY_STAR},
    '{4'd2, 4'd5, 4'd8, 4'd0},
    '{4'd3, 4'd6, 4'd9, KEY_HASH}
  };

endpackage

FILE: src/kpsd_stream_if.sv
`timescale 1ns / 1ps

interface kpsd_in_if;
  import kpsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   col_lines;
  logic [ROW_W-1:0]   row_lines;

  modport source (output valid, output col_lines, output row_lines, input ready);
  modport sink (input valid, input col_lines, input row_lines, output ready);
endinterface

interface kpsd_out_if;
  import kpsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_code;
  logic [CLASS_W-1:0] duration_class;
  logic [COUNT_W-1:0] press_count;

  modport source (output valid, output key_code, output duration_class,
                  output press_count, input ready);
  modport sink (input valid, input key_code, input duration_class,
                input press_count, output ready);
endinterface

FILE: src/keypad_scan_press_duration_core.sv
`timescale 1ns / 1ps

// Keypad scanner with press duration classification.
// The in_ch channel takes one word per poll tick: the active-low column and
// row lines of a 3x4 keypad. While any column is low the key is encoded and
// the hold counter runs; the first tick with all columns high after a press
// yields one word on out_ch with the key code, a duration class and the count.
// Ticks that end no press yield nothing.
// An accepted word is held in an input register, is evaluated against the held
// key state and, if it ends a press, is placed in the result register, which
// presents it on out_ch.
// One word is taken every cycle; the single input register and the result
// register set that rate, and the input side is held off only while the
// result register holds a word that out_ch has not yet taken.
// The user must write the three limits through the APB port while the block is
// idle; the block does not enforce this. Reset restores the default limits,
// clears the press state and empties both registers.
module keypad_scan_press_duration_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpsd_pkg::APB_AW-1:0]   paddr,
  input  logic [kpsd_pkg::APB_DW-1:0]   pwdata,
  output logic [kpsd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  kpsd_in_if.sink                       in_ch,
  kpsd_out_if.source                    out_ch
);
  import kpsd_pkg::*;

  logic [LIMIT_W-1:0] short_limit;
  logic [LIMIT_W-1:0] medium_limit;
  logic [LIMIT_W-1:0] long_limit;
  reg_idx_t           reg_idx;
  logic               reg_write;

  logic               s1_valid;
  logic [COL_W-1:0]   s1_cols;
  logic [ROW_W-1:0]   s1_rows;
  logic               s1_advance;

  logic               held_flag;
  logic               held_flag_next;
  logic               row_seen;
  logic               row_seen_next;
  logic [1:0]         row_sel;
  logic [1:0]         row_sel_next;
  logic [KEY_W-1:0]   last_key;
  logic [KEY_W-1:0]   last_key_next;
  logic [COUNT_W-1:0] hold_count;
  logic [COUNT_W-1:0] hold_count_next;

  logic               pressed;
  logic               emit;
  logic [1:0]         col_sel;
  logic               row_hit;
  logic [1:0]         row_enc;
  logic [CLASS_W-1:0] class_now;

  logic               out_valid;
  logic [KEY_W-1:0]   out_key;
  logic [CLASS_W-1:0] out_class;
  logic [COUNT_W-1:0] out_count;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit  <= SHORT_LIMIT_RESET;
      medium_limit <= MEDIUM_LIMIT_RESET;
      long_limit   <= LONG_LIMIT_RESET;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_SHORT_LIMIT:  short_limit  <= pwdata[LIMIT_W-1:0];
        REG_MEDIUM_LIMIT: medium_limit <= pwdata[LIMIT_W-1:0];
        REG_LONG_LIMIT:   long_limit   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHORT_LIMIT:  prdata = {{(APB_DW-LIMIT_W){1'b0}}, short_limit};
      REG_MEDIUM_LIMIT: prdata = {{(APB_DW-LIMIT_W){1'b0}}, medium_limit};
      REG_LONG_LIMIT:   prdata = {{(APB_DW-LIMIT_W){1'b0}}, long_limit};
      default:          prdata = '0;
    endcase
  end

  assign s1_advance  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cols <= in_ch.col_lines;
      s1_rows <= in_ch.row_lines;
    end
  end

  always_comb begin
    pressed = s1_cols != '1;
    row_hit = s1_rows != '1;

    priority if (!s1_cols[0]) begin
      col_sel = 2'd0;
    end else if (!s1_cols[1]) begin
      col_sel = 2'd1;
    end else begin
      col_sel = 2'd2;
    end

    priority if (!s1_rows[0]) begin
      row_enc = 2'd0;
    end else if (!s1_rows[1]) begin
      row_enc = 2'd1;
    end else if (!s1_rows[2]) begin
      row_enc = 2'd2;
    end else begin
      row_enc = 2'd3;
    end

    priority if (hold_count <= short_limit) begin
      class_now = CLASS_SHORT;
    end else if (hold_count <= medium_limit) begin
      class_now = CLASS_MEDIUM;
    end else if (hold_count <= long_limit) begin
      class_now = CLASS_LONG;
    end else begin
      class_now = CLASS_HELD;
    end
  end

  always_comb begin
    held_flag_next  = held_flag;
    row_seen_next   = row_seen;
    row_sel_next    = row_sel;
    last_key_next   = last_key;
    hold_count_next = hold_count;
    emit            = 1'b0;
    if (pressed) begin
      if (row_hit) begin
        row_seen_next = 1'b1;
        row_sel_next  = row_enc;
      end
      if (row_seen_next) begin
        last_key_next = KEY_MAP[col_sel][row_sel_next];
      end
      held_flag_next = 1'b1;
      if (hold_count != '1) begin
        hold_count_next = hold_count + 1'b1;
      end
    end else if (held_flag) begin
      emit            = 1'b1;
      held_flag_next  = 1'b0;
      hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag  <= 1'b0;
      row_seen   <= 1'b0;
      row_sel    <= '0;
      last_key   <= '0;
      hold_count <= '0;
    end else if (s1_advance) begin
      held_flag  <= held_flag_next;
      row_seen   <= row_seen_next;
      row_sel    <= row_sel_next;
      last_key   <= last_key_next;
      hold_count <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_key   <= last_key;
      out_class <= class_now;
      out_count <= hold_count;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.key_code       = out_key;
  assign out_ch.duration_class = out_class;
  assign out_ch.press_count    = out_count;

  // A press in progress always has a non-zero, saturating count.
  a_held_count: assert property (@(posedge clk) disable iff (rst)
    held_flag == (hold_count != '0))
    else $error("press flag and hold count disagree");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_key <= KEY_HASH))
    else $error("key code out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count != '0))
    else $error("released press reported with zero count");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> s1_valid)
    else $error("input word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid && !held_flag))
    else $error("registers not empty after reset");

endmodule
